FILE: hw/rtl/sbt_pkg.sv
// Package for the semaphore blocking table: opcode and status codes.
// No dependencies.
package sbt_pkg;
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_OUT    = 2'd2;
    localparam logic [1:0] OP_HEAD   = 2'd3;
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
endpackage

FILE: hw/rtl/sbt_cam.sv
// Key match array of the semaphore blocking table: valid bits and keys in flops.
// Depends on sbt_pkg.
module sbt_cam
    import sbt_pkg::*;
#(
    parameter int NUM_ENT  = 32,
    parameter int KEY_BITS = 32,
    localparam int EW = (NUM_ENT > 1) ? $clog2(NUM_ENT) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic                i_set,
    input  logic                i_clr,
    input  logic [EW-1:0]       i_idx,
    output logic                o_hit,
    output logic [EW-1:0]       o_hit_idx,
    output logic                o_free,
    output logic [EW-1:0]       o_free_idx
);
    logic [NUM_ENT-1:0]  r_valid;
    logic [KEY_BITS-1:0] r_key [NUM_ENT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_set) begin
            r_valid[i_idx] <= 1'b1;
            r_key[i_idx]   <= i_key;
        end else if (i_clr) begin
            r_valid[i_idx] <= 1'b0;
        end
    end

    always_comb begin
        o_hit = 1'b0; o_hit_idx = '0; o_free = 1'b0; o_free_idx = '0;
        for (int e = NUM_ENT - 1; e >= 0; e--) begin
            if (r_valid[e] && r_key[e] == i_key) begin
                o_hit = 1'b1; o_hit_idx = EW'(e);
            end
            if (!r_valid[e]) begin
                o_free = 1'b1; o_free_idx = EW'(e);
            end
        end
    end
endmodule

FILE: hw/rtl/semaphore_blocking_table.sv
// Semaphore blocking table top level: FSM over link memories, key match array.
// Depends on sbt_pkg and sbt_cam.
//
// Slave channel carries one command transaction: opcode, key, process number.
// Master channel returns exactly one result transaction per command.
// Insert, peek and failed commands pass through S_RD and S_WB to S_OUT (key match
// and read issue, read data, link write-back).
// Remove head and named removal that succeed also pass through S_ENT and S_RD2,
// which re-read the links once the head process or the owning entry is known.
// Insert of an already blocked process goes from S_RD to S_OUT with no change.
// Per-process link and per-entry queue memories are read through registers;
// the sequencer runs one command at a time.
// Slave tready is high only when idle and no result is pending; a stalled
// master holds the result and the block takes no new command until it is taken.
// Synchronous active-low reset clears valid and blocked bits; no clear pass.
module semaphore_blocking_table
    import sbt_pkg::*;
#(
    parameter int MAX_PROCS = 32,
    parameter int KEY_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] opcode, [33:2] sem_key, [38:34] proc_id
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [2] proc_valid, [7:3] proc_out
    output logic [7:0]  m_axis_tdata
);
    localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

    typedef enum logic [2:0] {S_IDLE, S_RD, S_ENT, S_RD2, S_WB, S_OUT} t_state;
    t_state r_state;

    logic [1:0]          r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [1:0]          r_status;
    logic                r_skip;
    logic                r_pv;
    logic [4:0]          r_pout;
    logic [MAX_PROCS-1:0] r_blk;
    logic                r_hit;
    logic [PW-1:0]       r_e;
    logic [PW-1:0]       r_p;

    logic [PW-1:0] m_head [MAX_PROCS];
    logic [PW-1:0] m_tail [MAX_PROCS];
    logic [PW-1:0] m_next [MAX_PROCS];
    logic [PW-1:0] m_prev [MAX_PROCS];
    logic [PW-1:0] m_pent [MAX_PROCS];
    logic [PW-1:0] r_hd, r_tl, r_nx, r_pr, r_pe;

    logic          c_hit, c_free, c_set, c_clr;
    logic [PW-1:0] c_hidx, c_fidx, c_idx;
    logic [KEY_BITS-1:0] c_key;
    logic          pid_ok;
    logic [PW-1:0] in_p;
    logic          in_blk;
    logic [1:0]    n_status;
    logic          n_skip;

    assign c_key  = KEY_BITS'(s_axis_tdata[33:2]);
    assign pid_ok = 32'(s_axis_tdata[38:34]) < 32'(MAX_PROCS);
    assign in_p   = PW'(s_axis_tdata[38:34]);
    assign in_blk = r_blk[in_p];

    sbt_cam #(.NUM_ENT(MAX_PROCS), .KEY_BITS(KEY_BITS)) u_cam (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_key(s_axis_tready ? c_key : r_key),
        .i_set(c_set), .i_clr(c_clr), .i_idx(c_idx),
        .o_hit(c_hit), .o_hit_idx(c_hidx), .o_free(c_free), .o_free_idx(c_fidx)
    );

    // Command check at acceptance.
    always_comb begin
        n_status = ST_OK;
        n_skip   = 1'b0;
        case (s_axis_tdata[1:0])
            OP_INSERT: begin
                if (!pid_ok) n_status = ST_NOTFOUND;
                else if (in_blk) n_skip = 1'b1;
                else if (!c_hit && !c_free) n_status = ST_FULL;
            end
            OP_OUT: if (!pid_ok || !in_blk) n_status = ST_NOTFOUND;
            default: if (!c_hit) n_status = ST_NOTFOUND;
        endcase
    end

    // Second stage after read: decisions for unlink/insert.
    logic          ul, is_h, is_t;
    logic [PW-1:0] up;
    assign ul   = r_op == OP_REMOVE || r_op == OP_OUT;
    assign up   = (r_op == OP_REMOVE) ? r_hd : r_p;
    assign is_h = r_hd == up;
    assign is_t = r_tl == up;

    always_comb begin
        c_set = 1'b0; c_clr = 1'b0; c_idx = r_e;
        if (r_state == S_WB) begin
            if (r_op == OP_INSERT && !r_hit && r_status == ST_OK) c_set = 1'b1;
            if (ul && r_status == ST_OK && is_h && is_t) c_clr = 1'b1;
        end
    end

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_state == S_OUT;
    assign m_axis_tdata  = {r_pout, r_pv, r_status};

    // Memory reads: per-entry ends at r_e, per-process links at r_p.
    always_ff @(posedge i_clk) begin
        r_hd <= m_head[r_e];
        r_tl <= m_tail[r_e];
        r_nx <= m_next[r_p];
        r_pr <= m_prev[r_p];
        r_pe <= m_pent[r_p];
    end

    // Memory writes in S_WB.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WB && r_status == ST_OK) begin
            if (r_op == OP_INSERT) begin
                if (r_hit) begin
                    m_next[r_tl] <= r_p;
                    m_prev[r_p]  <= r_tl;
                    m_tail[r_e]  <= r_p;
                end else begin
                    m_head[r_e] <= r_p;
                    m_tail[r_e] <= r_p;
                end
                m_pent[r_p] <= r_e;
            end else if (ul) begin
                if (is_h && !is_t) m_head[r_e] <= r_nx;
                else if (is_t && !is_h) m_tail[r_e] <= r_pr;
                else if (!is_h && !is_t) begin
                    m_next[r_pr] <= r_nx;
                    m_prev[r_nx] <= r_pr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_blk   <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_op     <= s_axis_tdata[1:0];
                    r_key    <= c_key;
                    r_p      <= in_p;
                    r_hit    <= c_hit;
                    r_pv     <= 1'b0;
                    r_pout   <= '0;
                    r_e      <= c_hit ? c_hidx : c_fidx;
                    r_status <= n_status;
                    r_skip   <= n_skip;
                    r_state  <= S_RD;
                end
                S_RD: begin
                    // blocked-already insert reports ok with no change
                    if (r_skip) r_state <= S_OUT;
                    else if (ul && r_status == ST_OK) r_state <= S_ENT;
                    else r_state <= S_WB;
                end
                S_ENT: begin
                    if (r_op == OP_OUT) r_e <= r_pe;
                    else r_p <= r_hd;
                    r_state <= S_RD2;
                end
                S_RD2: r_state <= S_WB;
                S_WB: begin
                    if (r_status == ST_OK) begin
                        if (r_op == OP_INSERT) r_blk[r_p] <= 1'b1;
                        if (ul) r_blk[up] <= 1'b0;
                        if (r_op != OP_INSERT) begin
                            r_pv   <= 1'b1;
                            r_pout <= (r_op == OP_HEAD) ? 5'(r_hd) : 5'(up);
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
